FILE: src/vltm_pkg.sv
package vltm_pkg;

  // Sizing
  localparam int NUM_THREADS     = 8;
  localparam int LOCK_ENTRIES    = 1024;
  localparam int READ_SET_DEPTH  = 16;
  localparam int WRITE_LOG_DEPTH = 16;
  localparam int STRIPE_BITS     = 6;

  localparam int TID_W    = 3;
  localparam int ADDR_W   = 48;
  localparam int DATA_W   = 64;
  localparam int LOCK_W   = 64;
  localparam int CLOCK_W  = 63;
  localparam int THR_W    = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int LK_W     = $clog2(LOCK_ENTRIES);
  localparam int RS_IDX_W = (READ_SET_DEPTH > 1) ? $clog2(READ_SET_DEPTH) : 1;
  localparam int LG_IDX_W = (WRITE_LOG_DEPTH > 1) ? $clog2(WRITE_LOG_DEPTH) : 1;
  localparam int MAX_DEPTH = (READ_SET_DEPTH > WRITE_LOG_DEPTH) ? READ_SET_DEPTH
                                                                : WRITE_LOG_DEPTH;
  localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
  localparam int RS_DEPTH = (1 << THR_W) << RS_IDX_W;
  localparam int LG_DEPTH = (1 << THR_W) << LG_IDX_W;

  // Request modes
  localparam logic [1:0] MODE_BEGIN  = 2'd0;
  localparam logic [1:0] MODE_LOAD   = 2'd1;
  localparam logic [1:0] MODE_STORE  = 2'd2;
  localparam logic [1:0] MODE_COMMIT = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_COMMITTED = 2'd1;
  localparam logic [1:0] ST_CONFLICT  = 2'd2;
  localparam logic [1:0] ST_CAPACITY  = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TID_W-1:0]  thread_id;
    logic [ADDR_W-1:0] address;
    logic [1:0]        access_size;
    logic [DATA_W-1:0] current_value;
    logic [DATA_W-1:0] store_value;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_value;
    logic [1:0]        write_size;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] old_value;
    logic [LOCK_W-1:0] prior_lock;
    logic [1:0]        size_code;
  } log_entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_DONE,
    S_CV_RD,
    S_CV_LK,
    S_CV_CHK,
    S_CM_RD,
    S_CM_LK,
    S_CM_WB,
    S_AB_RD,
    S_AB_EMIT
  } state_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] code);
    logic [DATA_W-1:0] m;
    case (code)
      2'd0:    m = DATA_W'(64'hFF);
      2'd1:    m = DATA_W'(64'hFFFF);
      2'd2:    m = DATA_W'(64'hFFFF_FFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [LK_W-1:0] stripe_of(input logic [ADDR_W-1:0] a);
    return a[STRIPE_BITS +: LK_W];
  endfunction

endpackage

FILE: src/vltm_ram.sv
module vltm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port; read data holds while idle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/versioned_lock_transaction_manager_unit.sv
// Versioned-lock transaction manager. Each request (begin, load, store, commit) for a
// thread gives one result, or one result per logged store when the transaction aborts,
// the final one marked by last. Requests are handled one at a time: begin and read-only
// commit go straight to the result, load and store take one lock table read, then the
// check and write-back, a commit reads, looks up and checks each read-set entry for
// revalidation and then reads, looks up and writes back each logged store for the lock
// release, and an abort reads and emits each logged store, each held longer while the
// result side stalls. These steps come from the lock table and the set/log memories,
// each with one write port and one registered read port. After reset the lock table is
// cleared one entry a cycle; requests wait until all LOCK_ENTRIES (1024) are clear.
module versioned_lock_transaction_manager_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vltm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output vltm_pkg::out_t out_data
);

  localparam int CW = vltm_pkg::CNT_W;

  vltm_pkg::state_t state_r, state_nxt;
  vltm_pkg::in_t    req_r, req_nxt;
  vltm_pkg::out_t   res_r, res_nxt;
  vltm_pkg::out_t   out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [vltm_pkg::CLOCK_W-1:0] clock_r, clock_nxt;
  logic [vltm_pkg::LOCK_W-1:0]  rv_r [vltm_pkg::NUM_THREADS];
  logic [vltm_pkg::LOCK_W-1:0]  rv_nxt [vltm_pkg::NUM_THREADS];
  logic [CW-1:0]    rs_cnt_r [vltm_pkg::NUM_THREADS];
  logic [CW-1:0]    rs_cnt_nxt [vltm_pkg::NUM_THREADS];
  logic [CW-1:0]    lg_cnt_r [vltm_pkg::NUM_THREADS];
  logic [CW-1:0]    lg_cnt_nxt [vltm_pkg::NUM_THREADS];
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [1:0]       ab_st_r, ab_st_nxt;
  logic [vltm_pkg::LK_W-1:0] clr_idx_r, clr_idx_nxt;

  // memory ports
  logic                        lk_wr_en, lk_rd_en;
  logic [vltm_pkg::LK_W-1:0]   lk_wr_addr, lk_rd_addr;
  logic [vltm_pkg::LOCK_W-1:0] lk_wr_data, lock_q;
  logic                        rs_wr_en, rs_rd_en;
  logic [$clog2(vltm_pkg::RS_DEPTH)-1:0] rs_wr_addr, rs_rd_addr;
  logic [vltm_pkg::LK_W-1:0]   rs_q;
  logic                        lg_wr_en, lg_rd_en;
  logic [$clog2(vltm_pkg::LG_DEPTH)-1:0] lg_wr_addr, lg_rd_addr;
  vltm_pkg::log_entry_t        lg_wr_data, log_q;

  // shared decode
  logic [vltm_pkg::TID_W-1:0]  t_sel;
  logic [vltm_pkg::THR_W-1:0]  thr;
  logic [vltm_pkg::LOCK_W-1:0] rv_sel, mine;
  logic [CW-1:0]               rs_cnt_sel, lg_cnt_sel, idx_inc, idx_dec;
  logic                        thread_ok_in, emit_ok;
  logic                        lock_rdok, lock_mine, rs_full, lg_full;
  logic                        acc_fail, store_eq, store_cap, cv_fail;
  logic [1:0]                  acc_st;
  logic [vltm_pkg::DATA_W-1:0] cur_m, val_m;

  vltm_ram #(.WIDTH(vltm_pkg::LOCK_W), .DEPTH(vltm_pkg::LOCK_ENTRIES)) u_lock_ram (
    .clk(clk), .wr_en(lk_wr_en), .wr_addr(lk_wr_addr), .wr_data(lk_wr_data),
    .rd_en(lk_rd_en), .rd_addr(lk_rd_addr), .rd_data(lock_q)
  );

  vltm_ram #(.WIDTH(vltm_pkg::LK_W), .DEPTH(vltm_pkg::RS_DEPTH)) u_rs_ram (
    .clk(clk), .wr_en(rs_wr_en), .wr_addr(rs_wr_addr), .wr_data(req_r.address[
      vltm_pkg::STRIPE_BITS +: vltm_pkg::LK_W]),
    .rd_en(rs_rd_en), .rd_addr(rs_rd_addr), .rd_data(rs_q)
  );

  vltm_ram #(.WIDTH($bits(vltm_pkg::log_entry_t)), .DEPTH(vltm_pkg::LG_DEPTH)) u_log_ram (
    .clk(clk), .wr_en(lg_wr_en), .wr_addr(lg_wr_addr), .wr_data(lg_wr_data),
    .rd_en(lg_rd_en), .rd_addr(lg_rd_addr), .rd_data(log_q)
  );

  // per-thread selection and checks on the lock word just read
  assign t_sel        = (state_r == vltm_pkg::S_IDLE) ? in_data.thread_id : req_r.thread_id;
  assign thr          = t_sel[vltm_pkg::THR_W-1:0];
  assign rv_sel       = rv_r[thr];
  assign rs_cnt_sel   = rs_cnt_r[thr];
  assign lg_cnt_sel   = lg_cnt_r[thr];
  assign idx_inc      = idx_r + CW'(1);
  assign idx_dec      = idx_r - CW'(1);
  assign thread_ok_in = int'(in_data.thread_id) < vltm_pkg::NUM_THREADS;
  assign emit_ok      = !out_valid_r || !out_stall;
  assign mine         = {{(vltm_pkg::LOCK_W-vltm_pkg::TID_W-1){1'b0}}, req_r.thread_id, 1'b1};
  assign lock_rdok    = !lock_q[0] && (lock_q <= rv_sel);
  assign lock_mine    = lock_q == mine;
  assign rs_full      = rs_cnt_sel >= CW'(vltm_pkg::READ_SET_DEPTH);
  assign lg_full      = lg_cnt_sel >= CW'(vltm_pkg::WRITE_LOG_DEPTH);
  assign acc_fail     = lock_rdok ? rs_full : !lock_mine;
  assign acc_st       = lock_rdok ? vltm_pkg::ST_CAPACITY : vltm_pkg::ST_CONFLICT;
  assign cur_m        = req_r.current_value & vltm_pkg::size_mask(req_r.access_size);
  assign val_m        = req_r.store_value & vltm_pkg::size_mask(req_r.access_size);
  assign store_eq     = cur_m == val_m;
  assign store_cap    = (req_r.mode == vltm_pkg::MODE_STORE) && !store_eq && lg_full;
  assign cv_fail      = lock_q[0] ? !lock_mine : (lock_q > rv_sel);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vltm_pkg::S_CLEAR: begin
        if (clr_idx_r == '1) state_nxt = vltm_pkg::S_IDLE;
      end
      vltm_pkg::S_IDLE: begin
        if (in_valid) begin
          if (!thread_ok_in) begin
            state_nxt = vltm_pkg::S_DONE;
          end else begin
            case (in_data.mode)
              vltm_pkg::MODE_LOAD, vltm_pkg::MODE_STORE: state_nxt = vltm_pkg::S_ACC;
              vltm_pkg::MODE_COMMIT: begin
                if (lg_cnt_sel == '0)      state_nxt = vltm_pkg::S_DONE;
                else if (rs_cnt_sel == '0) state_nxt = vltm_pkg::S_CM_RD;
                else                       state_nxt = vltm_pkg::S_CV_RD;
              end
              default: state_nxt = vltm_pkg::S_DONE;
            endcase
          end
        end
      end
      vltm_pkg::S_ACC: begin
        if ((acc_fail || store_cap) && lg_cnt_sel != '0) state_nxt = vltm_pkg::S_AB_RD;
        else                                           state_nxt = vltm_pkg::S_DONE;
      end
      vltm_pkg::S_DONE: begin
        if (emit_ok) state_nxt = vltm_pkg::S_IDLE;
      end
      vltm_pkg::S_CV_RD: state_nxt = vltm_pkg::S_CV_LK;
      vltm_pkg::S_CV_LK: state_nxt = vltm_pkg::S_CV_CHK;
      vltm_pkg::S_CV_CHK: begin
        if (cv_fail)                   state_nxt = vltm_pkg::S_AB_RD;
        else if (idx_inc == rs_cnt_sel) state_nxt = vltm_pkg::S_CM_RD;
        else                           state_nxt = vltm_pkg::S_CV_RD;
      end
      vltm_pkg::S_CM_RD: state_nxt = vltm_pkg::S_CM_LK;
      vltm_pkg::S_CM_LK: state_nxt = vltm_pkg::S_CM_WB;
      vltm_pkg::S_CM_WB: begin
        if (idx_inc == lg_cnt_sel) state_nxt = vltm_pkg::S_DONE;
        else                       state_nxt = vltm_pkg::S_CM_RD;
      end
      vltm_pkg::S_AB_RD: state_nxt = vltm_pkg::S_AB_EMIT;
      vltm_pkg::S_AB_EMIT: begin
        if (emit_ok) begin
          if (idx_r == CW'(1)) state_nxt = vltm_pkg::S_IDLE;
          else                 state_nxt = vltm_pkg::S_AB_RD;
        end
      end
      default: state_nxt = vltm_pkg::S_IDLE;
    endcase
  end

  // datapath, memory controls and results
  always_comb begin
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    clock_nxt     = clock_r;
    rv_nxt        = rv_r;
    rs_cnt_nxt    = rs_cnt_r;
    lg_cnt_nxt    = lg_cnt_r;
    idx_nxt       = idx_r;
    ab_st_nxt     = ab_st_r;
    clr_idx_nxt   = clr_idx_r;
    lk_wr_en      = 1'b0;
    lk_wr_addr    = vltm_pkg::stripe_of(req_r.address);
    lk_wr_data    = mine;
    lk_rd_en      = 1'b0;
    lk_rd_addr    = vltm_pkg::stripe_of(in_data.address);
    rs_wr_en      = 1'b0;
    rs_wr_addr    = {thr, rs_cnt_sel[vltm_pkg::RS_IDX_W-1:0]};
    rs_rd_en      = 1'b0;
    rs_rd_addr    = {thr, idx_r[vltm_pkg::RS_IDX_W-1:0]};
    lg_wr_en      = 1'b0;
    lg_wr_addr    = {thr, lg_cnt_sel[vltm_pkg::LG_IDX_W-1:0]};
    lg_wr_data    = '{address: req_r.address, old_value: cur_m, prior_lock: lock_q,
                      size_code: req_r.access_size};
    lg_rd_en      = 1'b0;
    lg_rd_addr    = {thr, idx_r[vltm_pkg::LG_IDX_W-1:0]};

    case (state_r)
      // lock table clearing sweep
      vltm_pkg::S_CLEAR: begin
        lk_wr_en    = 1'b1;
        lk_wr_addr  = clr_idx_r;
        lk_wr_data  = '0;
        clr_idx_nxt = clr_idx_r + vltm_pkg::LK_W'(1);
      end
      // take a request
      vltm_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          res_nxt.last = 1'b1;
          if (!thread_ok_in) begin
            res_nxt.status = vltm_pkg::ST_CONFLICT;
          end else begin
            case (in_data.mode)
              vltm_pkg::MODE_BEGIN: begin
                rv_nxt[thr]     = {clock_r, 1'b0};
                rs_cnt_nxt[thr] = '0;
                lg_cnt_nxt[thr] = '0;
              end
              vltm_pkg::MODE_LOAD, vltm_pkg::MODE_STORE: begin
                lk_rd_en = 1'b1;
              end
              vltm_pkg::MODE_COMMIT: begin
                res_nxt.status = vltm_pkg::ST_COMMITTED;
                idx_nxt        = '0;
                if (lg_cnt_sel == '0) begin
                  rs_cnt_nxt[thr] = '0;
                end else if (rs_cnt_sel == '0) begin
                  clock_nxt = clock_r + vltm_pkg::CLOCK_W'(1);
                end
              end
              default: res_nxt.status = vltm_pkg::ST_OK;
            endcase
          end
        end
      end
      // load / store check against the lock word
      vltm_pkg::S_ACC: begin
        if (lock_rdok && !rs_full) begin
          rs_wr_en        = 1'b1;
          rs_cnt_nxt[thr] = rs_cnt_sel + CW'(1);
        end
        if (acc_fail || store_cap) begin
          ab_st_nxt = acc_fail ? acc_st : vltm_pkg::ST_CAPACITY;
          idx_nxt   = lg_cnt_sel;
          res_nxt.status = ab_st_nxt;
          if (lg_cnt_sel == '0) begin
            rs_cnt_nxt[thr] = '0;
          end
        end else if (req_r.mode == vltm_pkg::MODE_STORE && !store_eq) begin
          lk_wr_en        = 1'b1;
          lg_wr_en        = 1'b1;
          lg_cnt_nxt[thr] = lg_cnt_sel + CW'(1);
          res_nxt.write_enable  = 1'b1;
          res_nxt.write_address = req_r.address;
          res_nxt.write_value   = val_m;
          res_nxt.write_size    = req_r.access_size;
        end
      end
      // single result
      vltm_pkg::S_DONE: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      // commit: revalidate read set
      vltm_pkg::S_CV_RD: begin
        rs_rd_en = 1'b1;
      end
      vltm_pkg::S_CV_LK: begin
        lk_rd_en   = 1'b1;
        lk_rd_addr = rs_q;
      end
      vltm_pkg::S_CV_CHK: begin
        if (cv_fail) begin
          ab_st_nxt = vltm_pkg::ST_CONFLICT;
          idx_nxt   = lg_cnt_sel;
        end else if (idx_inc == rs_cnt_sel) begin
          clock_nxt = clock_r + vltm_pkg::CLOCK_W'(1);
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      // commit: release owned stripes to the new version
      vltm_pkg::S_CM_RD: begin
        lg_rd_en = 1'b1;
      end
      vltm_pkg::S_CM_LK: begin
        lk_rd_en   = 1'b1;
        lk_rd_addr = vltm_pkg::stripe_of(log_q.address);
      end
      vltm_pkg::S_CM_WB: begin
        lk_wr_en   = lock_mine;
        lk_wr_addr = vltm_pkg::stripe_of(log_q.address);
        lk_wr_data = {clock_r, 1'b0};
        idx_nxt    = idx_inc;
        if (idx_inc == lg_cnt_sel) begin
          rs_cnt_nxt[thr] = '0;
          lg_cnt_nxt[thr] = '0;
        end
      end
      // abort: undo the log newest first
      vltm_pkg::S_AB_RD: begin
        lg_rd_en   = 1'b1;
        lg_rd_addr = {thr, idx_dec[vltm_pkg::LG_IDX_W-1:0]};
      end
      vltm_pkg::S_AB_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ab_st_r, write_enable: 1'b1,
                            write_address: log_q.address, write_value: log_q.old_value,
                            write_size: log_q.size_code, last: idx_r == CW'(1)};
          lk_wr_en   = 1'b1;
          lk_wr_addr = vltm_pkg::stripe_of(log_q.address);
          lk_wr_data = log_q.prior_lock;
          idx_nxt    = idx_dec;
          if (idx_r == CW'(1)) begin
            rs_cnt_nxt[thr] = '0;
            lg_cnt_nxt[thr] = '0;
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vltm_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
      clock_r     <= '0;
      clr_idx_r   <= '0;
      for (int i = 0; i < vltm_pkg::NUM_THREADS; i++) begin
        rv_r[i]     <= '0;
        rs_cnt_r[i] <= '0;
        lg_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clock_r     <= clock_nxt;
      clr_idx_r   <= clr_idx_nxt;
      rv_r        <= rv_nxt;
      rs_cnt_r    <= rs_cnt_nxt;
      lg_cnt_r    <= lg_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    idx_r      <= idx_nxt;
    ab_st_r    <= ab_st_nxt;
  end

  assign in_stall  = state_r != vltm_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_rs_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rs_cnt_sel <= CW'(vltm_pkg::READ_SET_DEPTH))
    else $error("read set count beyond depth");

  a_lg_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lg_cnt_sel <= CW'(vltm_pkg::WRITE_LOG_DEPTH))
    else $error("write log count beyond depth");

  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(clock_r)) |->
      ($past(state_r) == vltm_pkg::S_IDLE || $past(state_r) == vltm_pkg::S_CV_CHK))
    else $error("global clock moved outside commit");

  a_abort_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vltm_pkg::S_AB_EMIT && emit_ok) |=> (out_valid && out_data.write_enable))
    else $error("abort result without restore write");
`endif

endmodule
